// ===== rtl/core/pam_pkg.sv =====
// Shared types and constants of the pyramid affine map block.
package pam_pkg;

  localparam int unsigned CoordWidth  = 20;
  localparam int unsigned VertexWidth = 3 * CoordWidth;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned AWidth      = CoordWidth + 2;
  localparam int unsigned CofWidth    = 2 * AWidth + 1;
  localparam int unsigned DetWidth    = 3 * AWidth + 3;
  localparam int unsigned ProdWidth   = CofWidth + CoordWidth + 1;
  localparam int unsigned SumWidth    = ProdWidth + 2;
  localparam int unsigned QuoWidth    = CoordWidth + 1;

  typedef enum logic [1:0] {
    REQ_FORWARD  = 2'd0,
    REQ_INVERSE  = 2'd1,
    REQ_JACOBIAN = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    JAC_XI   = 2'd0,
    JAC_ETA  = 2'd1,
    JAC_ZETA = 2'd2
  } jac_col_e;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    req_type_e  req_type;
    coord_t     coord_first;
    coord_t     coord_second;
    coord_t     coord_third;
    jac_col_e   jac_column;
  } req_t;

  typedef struct packed {
    coord_t out_first;
    coord_t out_second;
    coord_t out_third;
    logic   singular;
    logic   saturated;
  } rsp_t;

  typedef struct packed {
    logic [2:0][2:0][AWidth-1:0]   a;
    logic [2:0][2:0][CofWidth-1:0] cof;
    logic [DetWidth-1:0]           dmag;
    logic                          dneg;
    logic                          dzero;
  } matrix_t;

  typedef struct packed {
    logic                        inv;
    logic                        kill;
    logic                        sing;
    logic [2:0]                  neg;
    logic [2:0][SumWidth-1:0]    mag;
  } side_t;

endpackage

// ===== rtl/core/pam_matrix.sv =====
// Matrix, cofactor and determinant terms derived from the vertex registers.
module pam_matrix (
  input  logic                                   clk_i,
  input  logic [3:0][pam_pkg::VertexWidth-1:0]   vtx_i,
  output pam_pkg::matrix_t                       mat_o
);

  localparam int unsigned W  = pam_pkg::CoordWidth;
  localparam int unsigned AW = pam_pkg::AWidth;
  localparam int unsigned CW = pam_pkg::CofWidth;
  localparam int unsigned DW = pam_pkg::DetWidth;

  logic signed [W-1:0]       vert [4][3];
  logic signed [AW-1:0]      a_d [3][3];
  logic signed [AW-1:0]      a_q [3][3];
  logic signed [CW-1:0]      cof_d [3][3];
  logic signed [CW-1:0]      cof_q [3][3];
  logic signed [AW+CW-1:0]   det_prod [3];
  logic signed [DW-1:0]      det_d;
  logic signed [DW-1:0]      det_q;
  logic [DW-1:0]             dmag_q;
  logic                      dneg_q;
  logic                      dzero_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        vert[k][r] = $signed(vtx_i[k][r*W +: W]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      a_d[r][0] = (AW'(vert[1][r]) - AW'(vert[0][r])) <<< 1;
      a_d[r][1] = (AW'(vert[2][r]) - AW'(vert[0][r])) <<< 1;
      a_d[r][2] = (AW'(vert[3][r]) <<< 1) - AW'(vert[1][r]) - AW'(vert[2][r]);
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      logic signed [2*AW-1:0] pa;
      logic signed [2*AW-1:0] pb;
      assign pa = a_q[I1][J1] * a_q[I2][J2];
      assign pb = a_q[I1][J2] * a_q[I2][J1];
      assign cof_d[gi][gj] = CW'(pa) - CW'(pb);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      det_prod[c] = a_q[0][c] * cof_q[0][c];
    end
    det_d = DW'(det_prod[0]) + DW'(det_prod[1]) + DW'(det_prod[2]);
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    cof_q   <= cof_d;
    det_q   <= det_d;
    dneg_q  <= det_q[DW-1];
    dzero_q <= (det_q == '0);
    dmag_q  <= det_q[DW-1] ? (~det_q + 1'b1) : det_q;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat_o.a[r][c]   = a_q[r][c];
        mat_o.cof[r][c] = cof_q[r][c];
      end
    end
    mat_o.dmag  = dmag_q;
    mat_o.dneg  = dneg_q;
    mat_o.dzero = dzero_q;
  end

endmodule

// ===== rtl/core/pam_div.sv =====
// Three-lane restoring divider pipeline: an overflow check stage, then one quotient bit per stage.
module pam_div #(
  parameter int unsigned NumWidth  = 81,
  parameter int unsigned DenWidth  = 70,
  parameter int unsigned QuoWidth  = 21,
  parameter int unsigned SideWidth = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [2:0][NumWidth-1:0]       num_i,
  input  logic [DenWidth-1:0]            den_i,
  input  logic [SideWidth-1:0]           side_i,
  output logic                           valid_o,
  output logic [2:0][QuoWidth-1:0]       quo_o,
  output logic [2:0]                     ovf_o,
  output logic [SideWidth-1:0]           side_o
);

  localparam int unsigned RemWidth = (NumWidth > DenWidth + QuoWidth) ?
                                     NumWidth : DenWidth + QuoWidth;
  localparam int unsigned Stages   = QuoWidth + 1;

  logic [Stages-1:0]                 valid_q;
  logic [RemWidth-1:0]               rem_q  [Stages-1][3];
  logic [QuoWidth-1:0]               quo_q  [Stages][3];
  logic [2:0]                        ovf_q  [Stages];
  logic [SideWidth-1:0]              side_q [Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      rem_q[0][l] <= RemWidth'(num_i[l]);
      quo_q[0][l] <= '0;
      ovf_q[0][l] <= RemWidth'(num_i[l]) >= (RemWidth'(den_i) << QuoWidth);
    end
    side_q[0] <= side_i;
  end

  for (genvar s = 1; s < Stages; s++) begin : g_stage
    localparam int unsigned Bit = QuoWidth - s;
    logic [RemWidth-1:0] trial;
    logic [RemWidth-1:0] rem_d  [3];
    logic [QuoWidth-1:0] quo_d  [3];

    assign trial = RemWidth'(den_i) << Bit;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_d[l] = rem_q[s-1][l];
        quo_d[l] = quo_q[s-1][l];
        if (rem_q[s-1][l] >= trial) begin
          rem_d[l]      = rem_q[s-1][l] - trial;
          quo_d[l][Bit] = 1'b1;
        end
      end
    end

    if (s < Stages - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s] <= rem_d;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s]  <= quo_d;
      ovf_q[s]  <= ovf_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign ovf_o   = ovf_q[Stages-1];
  assign side_o  = side_q[Stages-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_o[l] = quo_q[Stages-1][l];
    end
  end

endmodule

// ===== rtl/core/pyramid_affine_map_and_inverse_top.sv =====
// Top level of the pyramid affine map, inverse map and Jacobian column unit.
// Accepts one request per cycle while busy is low and returns each result on done_o for one
// cycle; every request type takes the same path: stages 1 to 3, the 22-stage divider
// pipeline (overflow check plus one quotient bit per stage) and the output register. Results
// cannot be held off by the receiver. After reset and after every vertex write, busy stays
// high while the matrix, cofactor and determinant registers settle.
module pyramid_affine_map_and_inverse_top #(
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  pam_pkg::req_t                         req_i,
  output logic                                  done_o,
  output pam_pkg::rsp_t                         rsp_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pam_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [pam_pkg::VertexWidth-1:0]       cfg_data_i
);

  localparam int unsigned W        = pam_pkg::CoordWidth;
  localparam int unsigned AW       = pam_pkg::AWidth;
  localparam int unsigned CW       = pam_pkg::CofWidth;
  localparam int unsigned DW       = pam_pkg::DetWidth;
  localparam int unsigned PW       = pam_pkg::ProdWidth;
  localparam int unsigned SW       = pam_pkg::SumWidth;
  localparam int unsigned QW       = pam_pkg::QuoWidth;
  localparam int unsigned NW       = SW + FRAC_BITS + 3;
  localparam int unsigned SideW    = $bits(pam_pkg::side_t);
  localparam int unsigned Latency  = QW + 5;
  localparam logic [2:0]  SettleCycles = 3'd4;
  localparam logic [SW:0]   FwdHalf  = (SW+1)'(1) << FRAC_BITS;
  localparam logic [SW-1:0] HalfRange = SW'(1) << (W - 1);
  localparam pam_pkg::coord_t MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam pam_pkg::coord_t MinVal = {1'b1, {(W-1){1'b0}}};

  logic [3:0][pam_pkg::VertexWidth-1:0] vtx_q;
  logic [2:0]                           settle_q;
  logic [2:0]                           settle_d;
  logic                                 accept;
  pam_pkg::matrix_t                     mat;
  logic signed [W-1:0]                  v0 [3];

  logic                                 s1_valid_q;
  pam_pkg::req_t                        s1_req_q;
  logic signed [W:0]                    s1_diff_q [3];
  logic signed [W-1:0]                  s1_crd [3];

  logic                                 s2_valid_q;
  pam_pkg::req_type_e                   s2_type_q;
  pam_pkg::jac_col_e                    s2_col_q;
  logic signed [CW-1:0]                 op_a [3][3];
  logic signed [W:0]                    op_b [3];
  logic signed [PW-1:0]                 prod_d [3][3];
  logic signed [PW-1:0]                 s2_prod_q [3][3];

  logic                                 s3_valid_q;
  pam_pkg::req_type_e                   s3_type_q;
  pam_pkg::jac_col_e                    s3_col_q;
  logic signed [SW-1:0]                 sum_d [3];
  logic signed [SW-1:0]                 s3_sum_q [3];

  logic [SW-1:0]                        abs_sum [3];
  logic [SW:0]                          fwd_rnd [3];
  logic signed [AW-1:0]                 jac_a [3];
  logic [AW-1:0]                        jac_abs [3];
  logic [AW:0]                          jac_rnd [3];
  logic [2:0][NW-1:0]                   div_num;
  pam_pkg::side_t                       side_d;

  logic                                 div_valid;
  logic [2:0][QW-1:0]                   div_quo;
  logic [2:0]                           div_ovf;
  logic [SideW-1:0]                     div_side_raw;
  pam_pkg::side_t                       div_side;

  logic [SW-1:0]                        out_mag [3];
  logic [2:0]                           out_clip;
  pam_pkg::coord_t                      out_val [3];
  pam_pkg::rsp_t                        rsp_d;
  pam_pkg::rsp_t                        rsp_q;
  logic                                 done_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = (settle_q != '0);
  assign accept      = start && !busy;

  always_comb begin
    settle_d = settle_q;
    if (cfg_valid_i) begin
      settle_d = SettleCycles;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q    <= '0;
      settle_q <= SettleCycles;
    end else begin
      settle_q <= settle_d;
      if (cfg_valid_i) begin
        vtx_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  pam_matrix u_matrix (
    .clk_i (clk_i),
    .vtx_i (vtx_q),
    .mat_o (mat)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      v0[r] = $signed(vtx_q[0][r*W +: W]);
    end
  end

  // Stage 1: offset from the origin vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q     <= req_i;
    s1_diff_q[0] <= (W+1)'(req_i.coord_first)  - (W+1)'(v0[0]);
    s1_diff_q[1] <= (W+1)'(req_i.coord_second) - (W+1)'(v0[1]);
    s1_diff_q[2] <= (W+1)'(req_i.coord_third)  - (W+1)'(v0[2]);
  end

  // Stage 2: matrix times vector products
  assign s1_crd[0] = s1_req_q.coord_first;
  assign s1_crd[1] = s1_req_q.coord_second;
  assign s1_crd[2] = s1_req_q.coord_third;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      op_b[c] = (s1_req_q.req_type == pam_pkg::REQ_INVERSE) ? s1_diff_q[c] :
                (W+1)'(s1_crd[c]);
      for (int r = 0; r < 3; r++) begin
        op_a[r][c] = (s1_req_q.req_type == pam_pkg::REQ_INVERSE) ?
                     $signed(mat.cof[c][r]) : CW'($signed(mat.a[r][c]));
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = op_a[r][c] * op_b[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_type_q <= s1_req_q.req_type;
    s2_col_q  <= s1_req_q.jac_column;
    s2_prod_q <= prod_d;
  end

  // Stage 3: row sums, plus the scaled origin vertex for forward requests
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SW'(s2_prod_q[r][0]) + SW'(s2_prod_q[r][1]) + SW'(s2_prod_q[r][2]);
      if (s2_type_q == pam_pkg::REQ_FORWARD) begin
        sum_d[r] = sum_d[r] + (SW'(v0[r]) <<< (FRAC_BITS + 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s3_type_q <= s2_type_q;
    s3_col_q  <= s2_col_q;
    s3_sum_q  <= sum_d;
  end

  // Stage 4: magnitudes, rounding and divider operands
  always_comb begin
    side_d      = '0;
    side_d.inv  = (s3_type_q == pam_pkg::REQ_INVERSE);
    side_d.sing = (s3_type_q == pam_pkg::REQ_INVERSE) && mat.dzero;
    for (int r = 0; r < 3; r++) begin
      abs_sum[r] = s3_sum_q[r][SW-1] ? (~s3_sum_q[r] + 1'b1) : s3_sum_q[r];
      fwd_rnd[r] = {1'b0, abs_sum[r]} + FwdHalf;
      div_num[r] = (NW'(abs_sum[r]) << (FRAC_BITS + 2)) + NW'(mat.dmag);
      jac_a[r]   = '0;
      unique case (s3_col_q)
        pam_pkg::JAC_XI:   jac_a[r] = $signed(mat.a[r][0]);
        pam_pkg::JAC_ETA:  jac_a[r] = $signed(mat.a[r][1]);
        pam_pkg::JAC_ZETA: jac_a[r] = $signed(mat.a[r][2]);
        default:           jac_a[r] = '0;
      endcase
      jac_abs[r] = jac_a[r][AW-1] ? (~jac_a[r] + 1'b1) : jac_a[r];
      jac_rnd[r] = ({1'b0, jac_abs[r]} + (AW+1)'(1)) >> 1;
    end
    unique case (s3_type_q)
      pam_pkg::REQ_FORWARD: begin
        for (int r = 0; r < 3; r++) begin
          side_d.neg[r] = s3_sum_q[r][SW-1];
          side_d.mag[r] = SW'(fwd_rnd[r] >> (FRAC_BITS + 1));
        end
      end
      pam_pkg::REQ_INVERSE: begin
        for (int r = 0; r < 3; r++) begin
          side_d.neg[r] = s3_sum_q[r][SW-1] ^ mat.dneg;
        end
      end
      pam_pkg::REQ_JACOBIAN: begin
        side_d.kill = !(s3_col_q == pam_pkg::JAC_XI || s3_col_q == pam_pkg::JAC_ETA ||
                        s3_col_q == pam_pkg::JAC_ZETA);
        for (int r = 0; r < 3; r++) begin
          side_d.neg[r] = jac_a[r][AW-1];
          side_d.mag[r] = SW'(jac_rnd[r][AW-1:0]);
        end
      end
      default: side_d.kill = 1'b1;
    endcase
  end

  pam_div #(
    .NumWidth  (NW),
    .DenWidth  (DW + 1),
    .QuoWidth  (QW),
    .SideWidth (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid_q),
    .num_i   (div_num),
    .den_i   ({mat.dmag, 1'b0}),
    .side_i  (side_d),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf),
    .side_o  (div_side_raw)
  );

  assign div_side = pam_pkg::side_t'(div_side_raw);

  // Output stage: sign, saturate, zero all lanes of killed and singular requests
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_mag[r]  = div_side.inv ? SW'(div_quo[r]) : div_side.mag[r];
      out_clip[r] = (div_side.inv && div_ovf[r]) ||
                    (out_mag[r] > (div_side.neg[r] ? HalfRange : HalfRange - 1'b1));
      if (out_clip[r]) begin
        out_val[r] = div_side.neg[r] ? MinVal : MaxVal;
      end else begin
        out_val[r] = div_side.neg[r] ? -out_mag[r][W-1:0] : out_mag[r][W-1:0];
      end
      if (div_side.kill || div_side.sing) begin
        out_val[r]  = '0;
        out_clip[r] = 1'b0;
      end
    end
    rsp_d.out_first  = out_val[0];
    rsp_d.out_second = out_val[1];
    rsp_d.out_third  = out_val[2];
    rsp_d.singular   = div_side.sing;
    rsp_d.saturated  = |out_clip;
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result strobe does not follow its request by the pipeline latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.singular) |-> (rsp_o.out_first == '0 && rsp_o.out_second == '0 &&
                                    rsp_o.out_third == '0 && !rsp_o.saturated))
    else $error("singular result carries nonzero data or saturation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> busy)
    else $error("request taken before matrix terms settled after a vertex write");

endmodule
